### rtl/tpl_pkg.sv
package tpl_pkg;

  localparam int WAYS    = 16;
  localparam int SETS    = 64;
  localparam int TAG_W   = 32;
  localparam int WAY_W   = $clog2(WAYS);
  localparam int SET_W   = $clog2(SETS);
  localparam int FILL_W  = $clog2(WAYS + 1);
  localparam int NODE_W  = $clog2(WAYS - 1);

  typedef logic [WAYS-2:0]             tree_t;
  typedef logic [WAYS-1:0][TAG_W-1:0]  tag_row_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    tree_t             tree;
  } meta_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
  } match_t;

  typedef enum logic [1:0] {
    KIND_ACCESS = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

  // Follow the direction bits from the root; way bits settle MSB first.
  function automatic logic [WAY_W-1:0] victim_of(tree_t t);
    logic [WAY_W-1:0]  w;
    logic [NODE_W-1:0] n;
    w = '0;
    for (int l = 0; l < WAY_W; l++) begin
      n = NODE_W'((1 << l) - 1) + NODE_W'(w >> (WAY_W - l));
      w[WAY_W-1-l] = t[n];
    end
    return w;
  endfunction

  // Point every node on the way's path away from it.
  function automatic tree_t touch(tree_t t, logic [WAY_W-1:0] w);
    tree_t             r;
    logic [NODE_W-1:0] n;
    r = t;
    for (int l = 0; l < WAY_W; l++) begin
      n = NODE_W'((1 << l) - 1) + NODE_W'(w >> (WAY_W - l));
      r[n] = ~w[WAY_W-1-l];
    end
    return r;
  endfunction

endpackage

### rtl/tpl_way_match.sv
module tpl_way_match (
  input  tpl_pkg::tag_row_t          row,
  input  logic [tpl_pkg::FILL_W-1:0] fill,
  input  logic [tpl_pkg::TAG_W-1:0]  tag,
  output tpl_pkg::match_t            res
);

  // Compare filled ways only; the highest match wins.
  always_comb begin
    res = '0;
    for (int w = 0; w < tpl_pkg::WAYS; w++) begin
      if ((tpl_pkg::FILL_W'(w) < fill) && (row[w] == tag)) begin
        res.hit = 1'b1;
        res.way = tpl_pkg::WAY_W'(w);
      end
    end
  end

endmodule

### rtl/tree_plru_replacement.sv
// Tree pseudo-LRU replacement with a per-set tag store.
// Input channel (in_valid / in_stall): one request names a kind (access,
// insert, victim query), a set and a tag. Result channel (out_valid /
// out_stall): exactly one result per request, in request order.
// Each request reads the set's tag row and its tree/fill record from two
// synchronous memories, computes in the next cycle and writes back. The
// result is loaded into the output register at the end of the lookup
// cycle when that register is free. Because of the read-then-write pass
// through the set memories, a new request is taken only after the last
// one has left the lookup cycle.
// in_stall is high while a request is in the lookup cycle. A new request
// is taken while a finished result still waits in the output register.
// When the receiver stalls with a result held, the lookup cycle holds its
// read data and waits; nothing is dropped.
// Reset clears the per-set valid bits, so every tree reads as all-left and
// every fill count as zero; no clearing pass is needed. The tag store is
// not cleared: only filled ways are ever compared or reported.
module tree_plru_replacement (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_kind,
  input  logic [tpl_pkg::SET_W-1:0]   in_set_index,
  input  logic [tpl_pkg::TAG_W-1:0]   in_tag,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tpl_pkg::WAY_W-1:0]   out_way,
  output logic                        out_hit,
  output logic [tpl_pkg::TAG_W-1:0]   out_victim_tag,
  output logic                        out_victim_valid
);

  tpl_pkg::state_t   state_r, state_nxt;
  logic              accept;
  logic              done;

  // Request held for the lookup cycle
  logic [1:0]                 kind_r;
  logic [tpl_pkg::SET_W-1:0]  set_r;
  logic [tpl_pkg::TAG_W-1:0]  tag_r;

  // Memories and their registered read data
  tpl_pkg::tag_row_t  tag_mem [tpl_pkg::SETS];
  tpl_pkg::meta_t     meta_mem [tpl_pkg::SETS];
  logic [tpl_pkg::SETS-1:0] meta_vld_r;
  tpl_pkg::tag_row_t  tag_q_r;
  tpl_pkg::meta_t     meta_q_r;
  logic               meta_vld_q_r;
  tpl_pkg::meta_t     meta_rd;

  // Lookup results
  tpl_pkg::match_t    match;
  logic [tpl_pkg::WAY_W-1:0] victim;
  tpl_pkg::tag_row_t  tag_row_wr;
  tpl_pkg::meta_t     meta_wr;
  logic               tag_we;
  logic               meta_we;
  logic [tpl_pkg::WAY_W-1:0] res_way;
  logic               res_hit;
  logic [tpl_pkg::TAG_W-1:0] res_vtag;
  logic               res_vvalid;

  // Output register
  logic                        out_valid_r;
  logic [tpl_pkg::WAY_W-1:0]   out_way_r;
  logic                        out_hit_r;
  logic [tpl_pkg::TAG_W-1:0]   out_vtag_r;
  logic                        out_vvalid_r;

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tpl_pkg::ST_IDLE: if (in_valid) state_nxt = tpl_pkg::ST_LOOK;
      tpl_pkg::ST_LOOK: if (done)     state_nxt = tpl_pkg::ST_IDLE;
      default:          state_nxt = tpl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    done     = 1'b0;
    unique case (state_r)
      tpl_pkg::ST_IDLE: in_stall = 1'b0;
      tpl_pkg::ST_LOOK: done = !out_valid_r || !out_stall;
      default:          in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      set_r  <= in_set_index;
      tag_r  <= in_tag;
    end
  end

  // ---------------- memories ----------------
  // Read on accept only, so the read data holds while the lookup waits.
  // Writes happen only in the lookup cycle, never alongside a read.
  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[set_r] <= tag_row_wr;
    if (accept) tag_q_r <= tag_mem[in_set_index];
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[set_r] <= meta_wr;
    if (accept)  meta_q_r <= meta_mem[in_set_index];
  end

  // A set never written reads as empty with the tree pointing left.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meta_vld_r   <= '0;
      meta_vld_q_r <= 1'b0;
    end else begin
      if (meta_we) meta_vld_r[set_r] <= 1'b1;
      if (accept)  meta_vld_q_r <= meta_vld_r[in_set_index];
    end
  end

  assign meta_rd = meta_vld_q_r ? meta_q_r : '0;

  // ---------------- lookup ----------------
  tpl_way_match u_match (
    .row  (tag_q_r),
    .fill (meta_rd.fill),
    .tag  (tag_r),
    .res  (match)
  );

  assign victim = tpl_pkg::victim_of(meta_rd.tree);

  always_comb begin
    tag_row_wr = tag_q_r;
    meta_wr    = meta_rd;
    tag_we     = 1'b0;
    meta_we    = 1'b0;
    res_way    = '0;
    res_hit    = 1'b0;
    res_vtag   = '0;
    res_vvalid = 1'b0;
    case (kind_r)
      tpl_pkg::KIND_ACCESS: begin
        // A miss leaves the tree alone.
        if (match.hit) begin
          res_way      = match.way;
          res_hit      = 1'b1;
          meta_wr.tree = tpl_pkg::touch(meta_rd.tree, match.way);
          meta_we      = done;
        end
      end
      tpl_pkg::KIND_INSERT: begin
        // Fill the next empty way, or evict the tree's victim.
        if (meta_rd.fill < tpl_pkg::FILL_W'(tpl_pkg::WAYS)) begin
          res_way      = meta_rd.fill[tpl_pkg::WAY_W-1:0];
          meta_wr.fill = meta_rd.fill + tpl_pkg::FILL_W'(1);
        end else begin
          res_way    = victim;
          res_vtag   = tag_q_r[victim];
          res_vvalid = 1'b1;
        end
        tag_row_wr[res_way] = tag_r;
        meta_wr.tree        = tpl_pkg::touch(meta_rd.tree, res_way);
        res_hit             = 1'b1;
        tag_we              = done;
        meta_we             = done;
      end
      tpl_pkg::KIND_QUERY: begin
        res_way = victim;
        res_hit = 1'b1;
        if (tpl_pkg::FILL_W'(victim) < meta_rd.fill) begin
          res_vtag   = tag_q_r[victim];
          res_vvalid = 1'b1;
        end
      end
      default: begin
        // Unused kind: all-zero result, no update.
      end
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_way_r    <= res_way;
      out_hit_r    <= res_hit;
      out_vtag_r   <= res_vtag;
      out_vvalid_r <= res_vvalid;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_way          = out_way_r;
  assign out_hit          = out_hit_r;
  assign out_victim_tag   = out_vtag_r;
  assign out_victim_valid = out_vvalid_r;

endmodule

### test/tree_plru_replacement_test.sv
`timescale 1ns / 1ps

module tree_plru_replacement_test;
  import tpl_pkg::*;

  localparam int          PERIOD     = 20;
  localparam int          N_RANDOM   = 600;
  localparam int          LONG_HOLD  = 80;
  localparam logic [1:0]  KIND_RSVD  = 2'd3;  // unused encoding, must answer all zero

  // One expected result of the block.
  typedef struct packed {
    logic [WAY_W-1:0] way;
    logic             hit;
    logic [TAG_W-1:0] victim_tag;
    logic             victim_valid;
  } plru_result_t;

  // Scoreboard: shadow copy of the per-set trees, tag rows and fill counts,
  // plus the queue of results still owed by the block.
  class plru_scoreboard;
    logic [WAYS-2:0]  dir_bits [SETS];
    logic [TAG_W-1:0] tag_rows [SETS][WAYS];
    int unsigned      filled   [SETS];
    plru_result_t     owed_q   [$];
    int unsigned      errors, checked, access_hits, access_misses, evictions, rsvd_seen;

    function new();
      foreach (dir_bits[s]) begin
        dir_bits[s] = '0;
        filled[s]   = 0;
        foreach (tag_rows[s][w]) tag_rows[s][w] = '0;
      end
    endfunction

    // Point every node on the way's path away from it.
    function void touch_path(int unsigned s, int unsigned w);
      int unsigned node, parent;
      node = WAYS - 1 + w;
      while (node > 0) begin
        parent = (node - 1) / 2;
        dir_bits[s][parent] = (node == 2 * parent + 1);
        node = parent;
      end
    endfunction

    function int unsigned pick_victim(int unsigned s);
      int unsigned node;
      node = 0;
      while (node < WAYS - 1)
        node = dir_bits[s][node] ? 2 * node + 2 : 2 * node + 1;
      return node - (WAYS - 1);
    endfunction

    function void note_request(logic [1:0] kind, logic [SET_W-1:0] s, logic [TAG_W-1:0] t);
      plru_result_t r;
      int unsigned  fill;
      r    = '0;
      fill = filled[s];
      case (kind)
        KIND_ACCESS: begin
          // highest filled way holding the tag wins
          for (int w = 0; w < fill; w++)
            if (tag_rows[s][w] == t) begin
              r.way = WAY_W'(w);
              r.hit = 1'b1;
            end
          if (r.hit) begin
            touch_path(s, r.way);
            access_hits++;
          end else begin
            access_misses++;
          end
        end
        KIND_INSERT: begin
          if (fill < WAYS) begin
            r.way     = WAY_W'(fill);
            filled[s] = fill + 1;
          end else begin
            r.way          = WAY_W'(pick_victim(s));
            r.victim_tag   = tag_rows[s][r.way];
            r.victim_valid = 1'b1;
            evictions++;
          end
          tag_rows[s][r.way] = t;
          touch_path(s, r.way);
          r.hit = 1'b1;
        end
        KIND_QUERY: begin
          r.way = WAY_W'(pick_victim(s));
          if (r.way < fill) begin
            r.victim_tag   = tag_rows[s][r.way];
            r.victim_valid = 1'b1;
          end
          r.hit = 1'b1;
        end
        default: rsvd_seen++;
      endcase
      owed_q.insert(owed_q.size(), r);
    endfunction

    function void check_result(plru_result_t got);
      plru_result_t exp;
      checked++;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: way %0d hit %0b vtag %h vvalid %0b",
                 $time, got.way, got.hit, got.victim_tag, got.victim_valid);
        return;
      end
      exp = owed_q[0];
      owed_q.delete(0);
      if (got.way !== exp.way) begin
        errors++;
        $display("%0t: way expected %0d got %0d", $time, exp.way, got.way);
      end
      if (got.hit !== exp.hit) begin
        errors++;
        $display("%0t: hit expected %0b got %0b", $time, exp.hit, got.hit);
      end
      if (got.victim_tag !== exp.victim_tag) begin
        errors++;
        $display("%0t: victim_tag expected %h got %h", $time, exp.victim_tag, got.victim_tag);
      end
      if (got.victim_valid !== exp.victim_valid) begin
        errors++;
        $display("%0t: victim_valid expected %0b got %0b",
                 $time, exp.victim_valid, got.victim_valid);
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_kind;
  logic [SET_W-1:0]   in_set_index;
  logic [TAG_W-1:0]   in_tag;
  logic               out_valid;
  logic               out_stall;
  logic [WAY_W-1:0]   out_way;
  logic               out_hit;
  logic [TAG_W-1:0]   out_victim_tag;
  logic               out_victim_valid;

  plru_scoreboard     sb;
  logic [TAG_W-1:0]   tag_pool [16];
  logic [SET_W-1:0]   hot_sets [4];
  bit                 sender_burst;
  bit                 receiver_burst;
  bit                 long_hold_req;
  int unsigned        requests_sent;

  tree_plru_replacement i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_set_index     (in_set_index),
    .in_tag           (in_tag),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_way          (out_way),
    .out_hit          (out_hit),
    .out_victim_tag   (out_victim_tag),
    .out_victim_valid (out_victim_valid)
  );

  always #(PERIOD / 2) clk = ~clk;

  // Offer one request after a random gap; return at the edge that takes it.
  // Keep in_valid high across back-to-back requests so it never gets two
  // assignments in one step.
  task automatic send_request(logic [1:0] kind, logic [SET_W-1:0] s, logic [TAG_W-1:0] t);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) sender_burst = !sender_burst;
    gap = sender_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_set_index <= s;
    in_tag       <= t;
    // values read right after the edge are the ones the block saw at it
    do @(posedge clk); while (in_stall);
    sb.note_request(kind, s, t);
    requests_sent++;
  endtask

  // Drop valid and hold until every owed result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Mostly a few hot sets and a small tag pool, so sets fill up, tags
  // repeat and accesses hit; the rest is fully random to toggle every bit.
  task automatic random_request();
    logic [1:0]       kind;
    logic [SET_W-1:0] s;
    logic [TAG_W-1:0] t;
    int unsigned      pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      kind = KIND_ACCESS;
    else if (pick < 75) kind = KIND_INSERT;
    else if (pick < 95) kind = KIND_QUERY;
    else                kind = KIND_RSVD;
    s = ($urandom_range(0, 9) < 7) ? hot_sets[$urandom_range(0, 3)] : SET_W'($urandom);
    t = ($urandom_range(0, 9) < 7) ? tag_pool[$urandom_range(0, 15)] : $urandom;
    send_request(kind, s, t);
  endtask

  // Receiver: stall a random number of cycles, then take one result.
  // Once a long hold is requested, stall for a long stretch instead, so
  // the block backs up and stalls its input.
  initial begin
    int unsigned hold;
    bit          long_hold_done;
    out_stall      = 1'b0;
    receiver_burst = 1'b0;
    long_hold_done = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) receiver_burst = !receiver_burst;
      if (long_hold_req && !long_hold_done) begin
        hold           = LONG_HOLD;
        long_hold_done = 1'b1;
      end else begin
        hold = receiver_burst ? 0 : $urandom_range(0, 7);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result('{way: out_way, hit: out_hit, victim_tag: out_victim_tag,
                        victim_valid: out_victim_valid});
    end
  end

  initial begin
    #(PERIOD * 250_000);
    $display("FAIL tree_plru_replacement");
    $finish;
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = KIND_ACCESS;
    in_set_index   = '0;
    in_tag         = '0;
    sender_burst   = 1'b0;
    long_hold_req  = 1'b0;
    requests_sent  = 0;
    sb             = new();
    foreach (tag_pool[i]) tag_pool[i] = $urandom;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    hot_sets    = '{6'd0, 6'd63, 6'd21, 6'd42};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-set query and access miss, reserved kind, tag
    // extremes, duplicate tags, set index extremes.
    send_request(KIND_QUERY,  6'd0,  32'h0000_0000);  // victim way not filled yet
    send_request(KIND_ACCESS, 6'd0,  32'h0000_0000);  // miss on empty set
    send_request(KIND_RSVD,   6'd0,  32'hFFFF_FFFF);
    send_request(KIND_INSERT, 6'd63, 32'hFFFF_FFFF);
    send_request(KIND_INSERT, 6'd63, 32'h0000_0000);
    send_request(KIND_INSERT, 6'd63, 32'hFFFF_FFFF);  // same tag in two ways
    send_request(KIND_ACCESS, 6'd63, 32'hFFFF_FFFF);  // touch the higher one
    send_request(KIND_ACCESS, 6'd63, 32'h0000_0000);
    send_request(KIND_QUERY,  6'd63, 32'h1234_5678);
    send_request(KIND_ACCESS, 6'd63, 32'h1234_5678);  // miss leaves the tree alone
    send_request(KIND_INSERT, 6'd0,  32'hA5A5_5A5A);
    send_request(KIND_QUERY,  6'd0,  32'h5A5A_A5A5);
    send_request(KIND_ACCESS, 6'd0,  32'hA5A5_5A5A);
    send_request(KIND_RSVD,   6'd63, 32'h0000_0000);
    // fill set 5 to the brim, then evict and query the victim
    for (int w = 0; w < WAYS; w++)
      send_request(KIND_INSERT, 6'd5, TAG_W'(32'h5000_0000 + w));
    send_request(KIND_INSERT, 6'd5, 32'h5000_00FF);
    send_request(KIND_QUERY,  6'd5, 32'h0000_0000);

    // pause the sender until the directed part is fully answered
    drain_results();

    // start the random part with a long receiver hold
    long_hold_req = 1'b1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) drain_results();
      random_request();
    end

    drain_results();
    repeat (4) @(posedge clk);

    $display("Covered %0d requests: %0d access hits, %0d access misses, %0d evictions,",
             requests_sent, sb.access_hits, sb.access_misses, sb.evictions);
    $display("%0d reserved-kind requests, %0d results checked, %0d mismatches.",
             sb.rsvd_seen, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS tree_plru_replacement");
    end else begin
      $display("FAIL tree_plru_replacement");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/tpl_pkg.sv
rtl/tpl_way_match.sv
rtl/tree_plru_replacement.sv
test/tree_plru_replacement_test.sv
